### hw/rtl/mfb_pkg.sv
package mfb_pkg;

   localparam int DIM_W    = 9;
   localparam int STRIDE_W = 6;
   localparam int COORD_W  = 10;
   localparam int BADDR_W  = 13;
   localparam int PIXEL_W  = 8;
   // y * stride + byte stays below 256 * 63 + 63
   localparam int IDX_W    = 14;
   localparam int CSR_IDX_W = 2;

   localparam logic [PIXEL_W-1:0] FULL_MASK = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE    = 2'd2;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_INVERT = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BYTE,
      ST_CLIP,
      ST_BASE,
      ST_RD,
      ST_WR,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      cmd_type                    command;
      logic signed [COORD_W-1:0]  left_x;
      logic signed [COORD_W-1:0]  top_y;
      logic signed [COORD_W-1:0]  right_x;
      logic signed [COORD_W-1:0]  bottom_y;
      logic [BADDR_W-1:0]         byte_address;
      logic [PIXEL_W-1:0]         write_byte;
   } item_type;

   // effective settings, already saturated
   typedef struct packed {
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [STRIDE_W-1:0] stride;
   } cfg_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] read_byte;
      logic               applied;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

### hw/rtl/mfb_store.sv
module mfb_store #(
   parameter int FRAME_BYTES = 8192
) (
   input  logic                           clock,
   input  mfb_pkg::mem_ctl_type           mem_ctl,
   input  logic [$clog2(FRAME_BYTES)-1:0] mem_addr,
   input  logic [mfb_pkg::PIXEL_W-1:0]    mem_wdata,
   output logic [mfb_pkg::PIXEL_W-1:0]    mem_rdata
);
   import mfb_pkg::*;

   logic [PIXEL_W-1:0] store_ff [FRAME_BYTES];
   logic [PIXEL_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_ff[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rdata_ff <= store_ff[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

### hw/rtl/mfb_seq.sv
module mfb_seq #(
   parameter int FRAME_BYTES = 8192,
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mfb_pkg::item_type              item_in,
   input  logic                           item_valid,
   output logic                           item_ready,
   input  mfb_pkg::cfg_type               cfg,
   output mfb_pkg::result_type            result,
   output logic                           result_valid,
   input  logic                           result_free,
   output mfb_pkg::mem_ctl_type           mem_ctl,
   output logic [$clog2(FRAME_BYTES)-1:0] mem_addr,
   output logic [mfb_pkg::PIXEL_W-1:0]    mem_wdata,
   input  logic [mfb_pkg::PIXEL_W-1:0]    mem_rdata
);
   import mfb_pkg::*;

   localparam int AW     = $clog2(FRAME_BYTES);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int LIMW   = IDX_W + 3;

   seq_state_type        state_ff, state_in;
   item_type             item_ff, item_in_d;
   logic                 ok_ff, ok_in;
   logic [XW-1:0]        x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]        y_ff, y_in, y_end_ff, y_end_in;
   logic                 full_ff, full_in;
   logic [STRIDE_W-1:0]  b_ff, b_in, b_start_ff, b_start_in, b_end_ff, b_end_in;
   logic [IDX_W-1:0]     base_ff, base_in, idx_ff, idx_in;
   logic                 idx_ok_ff, idx_ok_in;
   logic [PIXEL_W-1:0]   mask_ff, mask_in;

   // clipping
   logic signed [COORD_W:0] xs0, xs1, ys0, ys1, ws, hs;
   logic                    reject;
   logic [XW-1:0]           x0c, x1c;
   logic [YW-1:0]           y0c, y1c;
   logic [DIM_W-1:0]        w_last, h_last;
   logic                    full_c;

   // shared address adder
   logic [STRIDE_W-1:0]  add_op;
   logic [IDX_W-1:0]     sum;
   logic                 sum_ok;
   logic [IDX_W-1:0]     prod;
   logic                 byte_ok;
   logic [PIXEL_W-1:0]   mask_lo, mask_hi, mask_c;
   logic                 row_end, last_row;

   assign xs0 = (COORD_W+1)'(item_ff.left_x);
   assign xs1 = (COORD_W+1)'(item_ff.right_x);
   assign ys0 = (COORD_W+1)'(item_ff.top_y);
   assign ys1 = (COORD_W+1)'(item_ff.bottom_y);
   assign ws  = $signed({2'b00, cfg.width});
   assign hs  = $signed({2'b00, cfg.height});
   assign w_last = cfg.width - 9'd1;
   assign h_last = cfg.height - 9'd1;

   assign reject = (xs0 > xs1) || (ys0 > ys1) ||
                   (xs0[COORD_W] && xs1[COORD_W]) || ((xs0 >= ws) && (xs1 >= ws)) ||
                   (ys0[COORD_W] && ys1[COORD_W]) || ((ys0 >= hs) && (ys1 >= hs));

   assign x0c = xs0[COORD_W] ? '0 : xs0[XW-1:0];
   assign x1c = (xs1 >= ws) ? w_last[XW-1:0] : xs1[XW-1:0];
   assign y0c = ys0[COORD_W] ? '0 : ys0[YW-1:0];
   assign y1c = (ys1 >= hs) ? h_last[YW-1:0] : ys1[YW-1:0];
   assign full_c = (x0c == '0) && (DIM_W'(x1c) == w_last);

   assign add_op  = (state_ff == ST_WR) ? cfg.stride : b_ff;
   assign sum     = base_ff + IDX_W'(add_op);
   assign sum_ok  = LIMW'(sum) < LIMW'(FRAME_BYTES);
   assign prod    = IDX_W'(y_ff) * IDX_W'(cfg.stride);
   assign byte_ok = (LIMW'(item_ff.byte_address) < LIMW'(FRAME_BYTES));

   assign mask_lo = (b_ff == b_start_ff) ? (FULL_MASK >> x0_ff[2:0]) : FULL_MASK;
   assign mask_hi = (b_ff == b_end_ff) ? (FULL_MASK << (3'd7 - x1_ff[2:0])) : FULL_MASK;
   assign mask_c  = full_ff ? FULL_MASK : (mask_lo & mask_hi);
   assign row_end  = (b_ff == b_end_ff);
   assign last_row = (y_ff == y_end_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               if (item_in.command == CMD_WRITE || item_in.command == CMD_READ) begin
                  state_in = ST_BYTE;
               end else begin
                  state_in = ST_CLIP;
               end
            end
         end
         ST_BYTE: state_in = ST_DONE;
         ST_CLIP: state_in = reject ? ST_DONE : ST_BASE;
         ST_BASE: state_in = ST_RD;
         ST_RD:   state_in = ST_WR;
         ST_WR:   state_in = (row_end && last_row) ? ST_DONE : ST_RD;
         ST_DONE: begin
            if (result_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      item_ready   = 1'b0;
      result_valid = 1'b0;
      result       = '0;
      mem_ctl      = '0;
      mem_addr     = AW'(idx_ff);
      mem_wdata    = (item_ff.command == CMD_INVERT) ? (mem_rdata ^ mask_ff)
                                                     : (mem_rdata & ~mask_ff);
      item_in_d  = item_ff;
      ok_in      = ok_ff;
      x0_in      = x0_ff;
      x1_in      = x1_ff;
      y_in       = y_ff;
      y_end_in   = y_end_ff;
      full_in    = full_ff;
      b_in       = b_ff;
      b_start_in = b_start_ff;
      b_end_in   = b_end_ff;
      base_in    = base_ff;
      idx_in     = idx_ff;
      idx_ok_in  = idx_ok_ff;
      mask_in    = mask_ff;
      case (state_ff)
         ST_IDLE: begin
            item_ready = 1'b1;
            if (item_valid) begin
               item_in_d = item_in;
            end
         end
         ST_BYTE: begin
            ok_in    = byte_ok;
            mem_addr = AW'(item_ff.byte_address);
            if (item_ff.command == CMD_WRITE) begin
               mem_ctl.wr_en = byte_ok;
               mem_wdata     = item_ff.write_byte;
            end else begin
               mem_ctl.rd_en = byte_ok;
            end
         end
         ST_CLIP: begin
            ok_in    = !reject;
            x0_in    = x0c;
            x1_in    = x1c;
            y_in     = y0c;
            y_end_in = y1c;
            full_in  = full_c;
            if (full_c) begin
               b_start_in = '0;
               b_end_in   = cfg.stride - 6'd1;
               b_in       = '0;
            end else begin
               b_start_in = STRIDE_W'(x0c >> 3);
               b_end_in   = STRIDE_W'(x1c >> 3);
               b_in       = STRIDE_W'(x0c >> 3);
            end
         end
         ST_BASE: begin
            base_in = prod;
         end
         ST_RD: begin
            idx_in        = sum;
            idx_ok_in     = sum_ok;
            mask_in       = mask_c;
            mem_addr      = AW'(sum);
            mem_ctl.rd_en = sum_ok;
         end
         ST_WR: begin
            // bytes beyond the store are skipped
            mem_ctl.wr_en = idx_ok_ff;
            if (row_end) begin
               if (!last_row) begin
                  y_in    = y_ff + 1'b1;
                  base_in = sum;
                  b_in    = b_start_ff;
               end
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         ST_DONE: begin
            result_valid     = 1'b1;
            result.applied   = ok_ff;
            result.read_byte = (item_ff.command == CMD_READ && ok_ff) ? mem_rdata : '0;
         end
         default: begin
            item_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in_d;
      ok_ff      <= ok_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y_ff       <= y_in;
      y_end_ff   <= y_end_in;
      full_ff    <= full_in;
      b_ff       <= b_in;
      b_start_ff <= b_start_in;
      b_end_ff   <= b_end_in;
      base_ff    <= base_in;
      idx_ff     <= idx_in;
      idx_ok_ff  <= idx_ok_in;
      mask_ff    <= mask_in;
   end

endmodule

### hw/rtl/mono_framebuffer_rect_op_core.sv
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tuser: command; tdata: rectangle, address, byte
// rsp       out        rsp_tvalid/rsp_tready   tdata: read_byte; tuser: applied
// csr       in         csr_we                  csr_index, csr_wdata
//
// Byte write or read: idle accepts it, the byte state accesses the store, done posts
// the response. Area command: clipping, row base, then a read and a write per byte
// of the clipped span (read, modify, write through one store port), then the
// response; a rejected rectangle skips to the response. Reset returns the settings
// to their defaults and empties the sequencer; store contents are kept.
// A stalled response holds the sequencer in its final state and the input not ready.
module mono_framebuffer_rect_op_core #(
   parameter int FRAME_BYTES = 8192,
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [9:0] left_x, [19:10] top_y, [29:20] right_x, [39:30] bottom_y,
   // [52:40] byte_address, [60:53] write_byte, [63:61] zero
   input  logic [63:0]                      req_tdata,
   // [1:0] command
   input  logic [1:0]                       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [7:0] read_byte
   output logic [7:0]                       rsp_tdata,
   // [0] applied
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [mfb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfb_pkg::DIM_W-1:0]        csr_wdata
);
   import mfb_pkg::*;

   localparam int AW = $clog2(FRAME_BYTES);

   logic [DIM_W-1:0]    width_ff, height_ff;
   logic [STRIDE_W-1:0] stride_ff;
   cfg_type             cfg;
   item_type            item;
   result_type          result;
   logic                result_valid, result_free;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;
   mem_ctl_type         mem_ctl;
   logic [AW-1:0]       mem_addr;
   logic [PIXEL_W-1:0]  mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         stride_ff <= 6'd32;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACTIVE_WIDTH:  width_ff  <= csr_wdata;
            CSR_ACTIVE_HEIGHT: height_ff <= csr_wdata;
            CSR_ROW_STRIDE:    stride_ff <= csr_wdata[STRIDE_W-1:0];
            default:           ;
         endcase
      end
   end

   // saturate settings into their working ranges
   always_comb begin
      if (width_ff == '0) begin
         cfg.width = 9'd1;
      end else if (width_ff > DIM_W'(MAX_WIDTH)) begin
         cfg.width = DIM_W'(MAX_WIDTH);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = 9'd1;
      end else if (height_ff > DIM_W'(MAX_HEIGHT)) begin
         cfg.height = DIM_W'(MAX_HEIGHT);
      end else begin
         cfg.height = height_ff;
      end
      cfg.stride = (stride_ff == '0) ? 6'd1 : stride_ff;
   end

   always_comb begin
      item.command      = cmd_type'(req_tuser);
      item.left_x       = req_tdata[9:0];
      item.top_y        = req_tdata[19:10];
      item.right_x      = req_tdata[29:20];
      item.bottom_y     = req_tdata[39:30];
      item.byte_address = req_tdata[52:40];
      item.write_byte   = req_tdata[60:53];
   end

   assign result_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (result_valid && result_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.read_byte;
   assign rsp_tuser  = rsp_ff.applied;

   mfb_seq #(
      .FRAME_BYTES (FRAME_BYTES),
      .MAX_WIDTH   (MAX_WIDTH),
      .MAX_HEIGHT  (MAX_HEIGHT)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .item_in      (item),
      .item_valid   (req_tvalid),
      .item_ready   (req_tready),
      .cfg          (cfg),
      .result       (result),
      .result_valid (result_valid),
      .result_free  (result_free),
      .mem_ctl      (mem_ctl),
      .mem_addr     (mem_addr),
      .mem_wdata    (mem_wdata),
      .mem_rdata    (mem_rdata)
   );

   mfb_store #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_store (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

endmodule

### hw/rtl/mfb_checker.sv
module mfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one transaction at a time: busy right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready high in the cycle after acceptance");

   // no response can be produced in the cycle after acceptance
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared too early");

   // rejected or out-of-range commands return zero data
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("non-zero data on a rejected command");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind mono_framebuffer_rect_op_core mfb_checker u_mfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mfb_pkg::*;

   localparam int FRAME_BYTES = 8192;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int LONG_HOLD   = 400;
   localparam int PHASE_ITEMS = 117;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum {PACE_FREE, PACE_COIN, PACE_SPARSE, PACE_COMB} pace_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata  = '0;
   logic [1:0]           req_tuser  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [7:0]           rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [DIM_W-1:0]     csr_wdata  = '0;

   // predictor state: settings as written, image of the frame store
   logic [DIM_W-1:0]     width_setting  = 9'd256;
   logic [DIM_W-1:0]     height_setting = 9'd256;
   logic [STRIDE_W-1:0]  stride_setting = 6'd32;
   logic [PIXEL_W-1:0]   frame_image [FRAME_BYTES];

   // bytes that will have been written once everything queued so far is taken
   bit                   byte_primed [FRAME_BYTES];
   int                   primed_list [$];
   int                   fill_list [$];

   item_type             frame_ops_waiting [$];
   result_type           replies_owed [$];

   int                   mismatches  = 0;
   int                   replies_seen = 0;
   int                   cycle_count = 0;
   int                   sender_gap  = 0;
   int                   burst_left  = 0;
   int                   stall_left  = 0;
   int                   pace_left   = 0;
   bit                   long_hold_req = 1'b0;
   pace_type             pace = PACE_FREE;

   mono_framebuffer_rect_op_core #(
      .FRAME_BYTES(FRAME_BYTES),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Walk the clipped rectangle. With commit set, apply it to the image;
   // otherwise record every stored byte it would read that has no value yet.
   function automatic bit sweep_rect(input item_type it, input bit commit);
      int w, h, st, x0, y0, x1, y1, sb, eb, lo, hi, idx;
      bit full_row, invert;
      logic [PIXEL_W-1:0] mask;
      w  = (width_setting == 0) ? 1 : (width_setting > MAX_WIDTH) ? MAX_WIDTH : width_setting;
      h  = (height_setting == 0) ? 1 :
           (height_setting > MAX_HEIGHT) ? MAX_HEIGHT : height_setting;
      st = (stride_setting == 0) ? 1 : stride_setting;
      x0 = $signed(it.left_x);
      y0 = $signed(it.top_y);
      x1 = $signed(it.right_x);
      y1 = $signed(it.bottom_y);
      invert = (it.command == CMD_INVERT);
      if (x0 > x1 || y0 > y1 || (x0 < 0 && x1 < 0) || (x0 >= w && x1 >= w) ||
          (y0 < 0 && y1 < 0) || (y0 >= h && y1 >= h))
         return 1'b0;
      if (x0 < 0) x0 = 0;
      if (x1 >= w) x1 = w - 1;
      if (y0 < 0) y0 = 0;
      if (y1 >= h) y1 = h - 1;
      full_row = (x0 == 0 && x1 >= w - 1);
      sb = full_row ? 0 : x0 >>> 3;
      eb = full_row ? st - 1 : x1 >>> 3;
      for (int y = y0; y <= y1; y++) begin
         for (int b = sb; b <= eb; b++) begin
            if (full_row) begin
               mask = FULL_MASK;
            end else begin
               lo = (b == sb) ? (x0 & 7) : 0;
               hi = (b == eb) ? (x1 & 7) : 7;
               mask = (FULL_MASK >> lo) & (FULL_MASK << (7 - hi));
            end
            idx = y * st + b;
            // bytes past the end of the store are skipped
            if (idx < FRAME_BYTES) begin
               if (commit) begin
                  frame_image[idx] = invert ? (frame_image[idx] ^ mask)
                                            : (frame_image[idx] & ~mask);
               end else if (!byte_primed[idx]) begin
                  byte_primed[idx] = 1'b1;
                  primed_list.push_back(idx);
                  fill_list.push_back(idx);
               end
            end
         end
      end
      return 1'b1;
   endfunction

   function automatic void predict_reply(input item_type it);
      result_type r;
      r = '0;
      case (it.command)
         CMD_WRITE: begin
            if (it.byte_address < FRAME_BYTES) begin
               frame_image[it.byte_address] = it.write_byte;
               r.applied = 1'b1;
            end
         end
         CMD_READ: begin
            if (it.byte_address < FRAME_BYTES) begin
               r.read_byte = frame_image[it.byte_address];
               r.applied   = 1'b1;
            end
         end
         default: r.applied = sweep_rect(it, 1'b1);
      endcase
      replies_owed.push_back(r);
   endfunction

   function automatic item_type byte_item(input cmd_type c, input int addr, input int data);
      item_type it;
      it.command      = c;
      it.left_x       = COORD_W'($urandom);
      it.top_y        = COORD_W'($urandom);
      it.right_x      = COORD_W'($urandom);
      it.bottom_y     = COORD_W'($urandom);
      it.byte_address = BADDR_W'(addr);
      it.write_byte   = PIXEL_W'(data);
      return it;
   endfunction

   function automatic item_type rect_item(input cmd_type c, input int x0, input int y0,
                                          input int x1, input int y1);
      item_type it;
      it = byte_item(c, $urandom, $urandom);
      it.left_x   = COORD_W'(x0);
      it.top_y    = COORD_W'(y0);
      it.right_x  = COORD_W'(x1);
      it.bottom_y = COORD_W'(y1);
      return it;
   endfunction

   function automatic item_type random_item();
      item_type it;
      cmd_type  c;
      int pick, w, h, x0, x1, y0, y1, t;
      w = width_setting;
      h = height_setting;
      pick = $urandom_range(0, 99);
      if (pick < 28 || (pick < 50 && primed_list.size() == 0))
         return byte_item(CMD_WRITE, $urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, FRAME_BYTES - 1),
                          $urandom);
      if (pick < 50)
         return byte_item(CMD_READ, primed_list[$urandom_range(0, primed_list.size() - 1)],
                          $urandom);
      c = $urandom_range(0, 1) ? CMD_INVERT : CMD_CLEAR;
      // raw noise over the whole coordinate range
      if (pick < 58) begin
         it = byte_item(CMD_WRITE, $urandom, $urandom);
         it.command = c;
         return it;
      end
      x0 = $urandom_range(0, w + 24) - 12;
      case ($urandom_range(0, 3))
         0: x1 = x0 + $urandom_range(0, 7);
         1: begin
            x0 = -$urandom_range(0, 4);
            x1 = w - 1 + $urandom_range(0, 4);
         end
         default: x1 = x0 + $urandom_range(0, w);
      endcase
      y0 = $urandom_range(0, h + 5) - 3;
      y1 = y0 + $urandom_range(0, 5);
      if ($urandom_range(0, 15) == 0) begin
         t = x0; x0 = x1 + 1; x1 = t;
      end
      if ($urandom_range(0, 15) == 0) begin
         t = y0; y0 = y1 + 1; y1 = t;
      end
      return rect_item(c, x0, y0, x1, y1);
   endfunction

   // Queue one transaction; an area command is preceded by writes to any
   // byte it would read before that byte holds a value.
   task automatic post_item(input item_type it);
      if (it.command == CMD_CLEAR || it.command == CMD_INVERT) begin
         fill_list.delete();
         void'(sweep_rect(it, 1'b0));
         foreach (fill_list[k])
            frame_ops_waiting.push_back(byte_item(CMD_WRITE, fill_list[k], $urandom));
      end else if (it.command == CMD_WRITE && !byte_primed[it.byte_address]) begin
         byte_primed[it.byte_address] = 1'b1;
         primed_list.push_back(it.byte_address);
      end
      frame_ops_waiting.push_back(it);
   endtask

   task automatic settle();
      while (frame_ops_waiting.size() != 0 || replies_owed.size() != 0)
         @(posedge clock);
   endtask

   task automatic load_settings(input int w, input int h, input int s);
      logic [CSR_IDX_W-1:0] regs [4];
      int vals [4];
      settle();
      regs = '{CSR_ACTIVE_WIDTH, CSR_ACTIVE_HEIGHT, CSR_ROW_STRIDE, CSR_UNUSED_INDEX};
      vals = '{w, h, s, $urandom};
      csr_we <= 1'b1;
      for (int k = 0; k < 4; k++) begin
         csr_index <= regs[k];
         csr_wdata <= vals[k][DIM_W-1:0];
         @(posedge clock);
         case (regs[k])
            CSR_ACTIVE_WIDTH:  width_setting  = vals[k][DIM_W-1:0];
            CSR_ACTIVE_HEIGHT: height_setting = vals[k][DIM_W-1:0];
            CSR_ROW_STRIDE:    stride_setting = vals[k][STRIDE_W-1:0];
            default: ;
         endcase
      end
      csr_we <= 1'b0;
   endtask

   task automatic test_byte_access();
      post_item(byte_item(CMD_WRITE, 0, 8'hFF));
      post_item(byte_item(CMD_WRITE, FRAME_BYTES - 1, 8'h00));
      post_item(byte_item(CMD_READ, 0, 8'h00));
      post_item(byte_item(CMD_READ, FRAME_BYTES - 1, 8'hFF));
      post_item(byte_item(CMD_WRITE, FRAME_BYTES - 1, 8'hA5));
      settle();
   endtask

   task automatic test_rect_rejects();
      post_item(rect_item(CMD_CLEAR, 5, 0, 4, 0));
      post_item(rect_item(CMD_INVERT, 0, 3, 7, 2));
      post_item(rect_item(CMD_CLEAR, -512, 0, -1, 0));
      post_item(rect_item(CMD_INVERT, 256, 0, 511, 0));
      post_item(rect_item(CMD_CLEAR, 0, -512, 7, -1));
      post_item(rect_item(CMD_INVERT, 0, 256, 7, 511));
      settle();
   endtask

   task automatic test_rect_spans();
      post_item(rect_item(CMD_CLEAR, -512, -3, 511, 0));
      post_item(rect_item(CMD_INVERT, 0, 1, 255, 1));
      post_item(rect_item(CMD_INVERT, 9, 0, 13, 1));
      // short span straddling a byte boundary must not merge the masks
      post_item(rect_item(CMD_CLEAR, 6, 0, 9, 0));
      post_item(rect_item(CMD_INVERT, 8, 1, 15, 1));
      post_item(rect_item(CMD_INVERT, 5, 0, 60, 1));
      post_item(rect_item(CMD_CLEAR, 250, 1, 400, 1));
      post_item(rect_item(CMD_INVERT, 0, 0, 254, 0));
      settle();
   endtask

   task automatic test_saturated_settings();
      load_settings(9'h1FF, 9'h1FF, 0);
      post_item(rect_item(CMD_INVERT, -1, -1, 511, 511));
      post_item(rect_item(CMD_CLEAR, 0, -512, 7, 511));
      load_settings(0, 0, 9'h1C4);
      post_item(rect_item(CMD_CLEAR, 0, 0, 0, 0));
      post_item(rect_item(CMD_INVERT, 1, 0, 5, 0));
      settle();
   endtask

   task automatic test_beyond_store();
      load_settings(256, 256, 63);
      post_item(rect_item(CMD_INVERT, -512, 128, 511, 511));
      post_item(rect_item(CMD_CLEAR, 3, 200, 100, 255));
      settle();
   endtask

   task automatic test_backpressure();
      load_settings(64, 8, 8);
      long_hold_req = 1'b1;
      repeat (48) post_item(random_item());
      settle();
   endtask

   task automatic test_random_mix();
      int widths [6]  = '{40, 256, 9, 130, 0, 200};
      int heights [6] = '{10, 16, 24, 0, 0, 20};
      int strides [6] = '{6, 32, 63, 17, 0, 9'h1C0};
      widths[4]  = $urandom_range(1, 300);
      heights[4] = $urandom_range(1, 20);
      strides[4] = $urandom_range(0, 63);
      for (int p = 0; p < 6; p++) begin
         load_settings(widths[p], heights[p], strides[p]);
         repeat (PHASE_ITEMS) post_item(random_item());
      end
      settle();
   endtask

   // Present queued transactions in bursts; hold each one until taken.
   always @(posedge clock) begin : req_driver
      item_type head;
      bit taken;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         taken = req_tvalid && req_tready;
         if (taken)
            predict_reply(frame_ops_waiting.pop_front());
         if (req_tvalid && !taken) begin
            // hold
         end else if (sender_gap > 0) begin
            sender_gap--;
            req_tvalid <= 1'b0;
         end else if (frame_ops_waiting.size() > 0) begin
            head = frame_ops_waiting[0];
            req_tvalid <= 1'b1;
            req_tuser  <= head.command;
            req_tdata  <= {3'b000, head.write_byte, head.byte_address, head.bottom_y,
                           head.right_x, head.top_y, head.left_x};
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               sender_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : rsp_pacer
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (pace_left == 0) begin
            pace      = pace_type'($urandom_range(0, 3));
            pace_left = $urandom_range(16, 160);
         end
         pace_left--;
         case (pace)
            PACE_FREE:   rsp_tready <= 1'b1;
            PACE_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            PACE_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default:     rsp_tready <= (pace_left % 4 != 0);
         endcase
      end
   end

   always @(posedge clock) begin : reply_check
      result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_byte = rsp_tdata;
         got.applied   = rsp_tuser;
         if (replies_owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("reply %0d with none outstanding: read_byte %02h applied %0b",
                        replies_seen, got.read_byte, got.applied);
         end else begin
            want = replies_owed.pop_front();
            if (got.read_byte !== want.read_byte || got.applied !== want.applied) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("reply %0d: expected read_byte %02h applied %0b, got %02h %0b",
                           replies_seen, want.read_byte, want.applied,
                           got.read_byte, got.applied);
            end
         end
         replies_seen++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : regression
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_byte_access();
      test_rect_rejects();
      test_rect_spans();
      test_backpressure();
      test_saturated_settings();
      test_beyond_store();
      test_random_mix();
      settle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && replies_owed.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/mfb_pkg.sv
hw/rtl/mfb_store.sv
hw/rtl/mfb_seq.sv
hw/rtl/mono_framebuffer_rect_op_core.sv
hw/rtl/mfb_checker.sv
sim/testbench.sv
